// File: sv/utf8d_pkg.sv
// shared widths, constants, lead byte decode and scalar check for the utf-8 stream decoder
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int LEN_W  = 3;
    localparam int CONT_W = 2;
    localparam int CNT_W  = 3;

    localparam logic [CP_W-1:0] MIN_2B  = 21'h00080;
    localparam logic [CP_W-1:0] MIN_3B  = 21'h00800;
    localparam logic [CP_W-1:0] MIN_4B  = 21'h10000;
    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h0D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h0DFFF;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_2B   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3B   = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4B   = 3'd4;

    // lead byte kinds
    localparam logic [1:0] LEAD_ASCII = 2'd0;
    localparam logic [1:0] LEAD_START = 2'd1;
    localparam logic [1:0] LEAD_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0]      kind;
        logic [LEN_W-1:0] len;
        logic [CP_W-1:0]  accum;
    } t_lead;

    function automatic t_lead decode_lead(input logic [BYTE_W-1:0] b);
        t_lead l;
        l.kind  = LEAD_BAD;
        l.len   = LEN_NONE;
        l.accum = '0;
        if (b[7] == 1'b0) begin
            l.kind  = LEAD_ASCII;
            l.accum = CP_W'(b);
        end else if ((b & 8'hE0) == 8'hC0) begin
            l.kind  = LEAD_START;
            l.len   = LEN_2B;
            l.accum = CP_W'(b & 8'h1F);
        end else if ((b & 8'hF0) == 8'hE0) begin
            l.kind  = LEAD_START;
            l.len   = LEN_3B;
            l.accum = CP_W'(b & 8'h0F);
        end else if ((b & 8'hF8) == 8'hF0) begin
            l.kind  = LEAD_START;
            l.len   = LEN_4B;
            l.accum = CP_W'(b & 8'h07);
        end
        return l;
    endfunction

    // overlong, surrogate and out-of-range check on a finished sequence
    function automatic logic scalar_good(input logic [CP_W-1:0] v,
                                         input logic [LEN_W-1:0] len);
        logic [CP_W-1:0] lim;
        case (len)
            LEN_2B:  lim = MIN_2B;
            LEN_3B:  lim = MIN_3B;
            default: lim = MIN_4B;
        endcase
        return (v >= lim) && (v <= CP_MAX) && !(v inside {[SURR_LO:SURR_HI]});
    endfunction

endpackage

// File: sv/utf8d_if.sv
// valid/ready channels for text bytes in and decoded scalars out
interface utf8d_in_if;
    import utf8d_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              text_last;

    modport source (output valid, output in_byte, output text_last, input ready);
    modport sink   (input valid, input in_byte, input text_last, output ready);
endinterface

interface utf8d_out_if;
    import utf8d_pkg::*;
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            scalar_ok;
    logic            run_last;
    logic            text_end;

    modport source (output valid, output code_point, output scalar_ok, output run_last,
                    output text_end, input ready);
    modport sink   (input valid, input code_point, input scalar_ok, input run_last,
                    input text_end, output ready);
endinterface

// File: sv/utf8_stream_decoder_unit.sv
// utf-8 stream decoder: text bytes in, unicode scalars or error markers out
//
// i_byte_ch carries one text byte per word plus a flag on the last byte of
// the text. o_cp_ch carries one result per word: a scalar with scalar_ok
// high, or an error marker with code_point zero. run_last flags the final
// result caused by one byte, text_end the final result of the whole text.
// a byte may cause no result (lead or middle of a sequence) or up to four
// (errors flushed from a broken or truncated sequence, then the new lead).
// an accepted byte waits in the input register, its results then in the
// result register. throughput: one byte per cycle while each byte causes
// at most one result and the receiver is ready; the result register drains
// one word per cycle while ready is high, so a byte with k results holds
// the input until all k are taken. the input register keeps taking a byte
// while the last result of the previous one waits in the result register.
// reset (synchronous, i_rst_n low) empties both registers and drops any
// pending sequence. when the receiver stalls, the result register holds
// its word, then the input register fills and i_byte_ch.ready goes low;
// nothing is lost or repeated.
module utf8_stream_decoder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    utf8d_in_if.sink             i_byte_ch,
    utf8d_out_if.source          o_cp_ch
);
    import utf8d_pkg::*;

    // input register
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // pending sequence state
    logic [LEN_W-1:0]  r_seq_len;
    logic [CONT_W-1:0] r_conts;
    logic [CP_W-1:0]   r_accum;

    // result register: count of words still to send; all but the final are errors
    logic              r_res_vld;
    logic [CNT_W-1:0]  r_cnt;
    logic [CP_W-1:0]   r_cp;
    logic              r_ok;
    logic              r_end;

    logic              n_seq_len_zero;
    logic [LEN_W-1:0]  n_seq_len;
    logic [CONT_W-1:0] n_conts;
    logic [CP_W-1:0]   n_accum;
    logic [CNT_W-1:0]  n_cnt;
    logic [CP_W-1:0]   n_cp;
    logic              n_ok;

    t_lead             lead;
    logic [CP_W-1:0]   acc_step;
    logic [CONT_W-1:0] conts_inc;
    logic              pending;
    logic              is_cont;
    logic              take_lead;
    logic              res_take;
    logic              res_free;
    logic              load;
    logic              in_take;

    // handshakes
    assign res_take = r_res_vld && o_cp_ch.ready;
    assign res_free = !r_res_vld || (res_take && (r_cnt == CNT_W'(1)));
    assign load     = r_in_vld && res_free;
    assign i_byte_ch.ready = !r_in_vld || load;
    assign in_take  = i_byte_ch.valid && i_byte_ch.ready;

    // decode of the byte in the input register against the pending sequence
    always_comb begin
        lead      = decode_lead(r_in_byte);
        acc_step  = {r_accum[CP_W-7:0], r_in_byte[5:0]};
        conts_inc = r_conts + CONT_W'(1);
        pending   = (r_seq_len >= LEN_2B) && (r_seq_len <= LEN_4B);
        is_cont   = (r_in_byte[7:6] == 2'b10);
        take_lead = 1'b0;
        n_seq_len = LEN_NONE;
        n_conts   = '0;
        n_accum   = '0;
        n_cnt     = '0;
        n_cp      = '0;
        n_ok      = 1'b0;

        if (pending && is_cont) begin
            if ((LEN_W'(conts_inc) + LEN_W'(1)) >= r_seq_len) begin
                // sequence complete: one scalar or one error for all of it
                n_cnt = CNT_W'(1);
                n_ok  = scalar_good(acc_step, r_seq_len);
                n_cp  = acc_step;
            end else begin
                n_seq_len = r_seq_len;
                n_conts   = conts_inc;
                n_accum   = acc_step;
            end
        end else if (pending) begin
            // broken sequence: error for the lead and each continuation, then retry as lead
            n_cnt     = CNT_W'(r_conts) + CNT_W'(1);
            take_lead = 1'b1;
        end else begin
            take_lead = 1'b1;
        end

        if (take_lead) begin
            case (lead.kind)
                LEAD_ASCII: begin
                    n_cnt = n_cnt + CNT_W'(1);
                    n_cp  = lead.accum;
                    n_ok  = 1'b1;
                end
                LEAD_START: begin
                    n_seq_len = lead.len;
                    n_accum   = lead.accum;
                end
                default: begin
                    n_cnt = n_cnt + CNT_W'(1);
                    n_ok  = 1'b0;
                end
            endcase
        end

        // text cut short inside a sequence
        n_seq_len_zero = (n_seq_len == LEN_NONE);
        if (r_in_last && !n_seq_len_zero) begin
            n_cnt     = n_cnt + CNT_W'(n_conts) + CNT_W'(1);
            n_ok      = 1'b0;
            n_seq_len = LEN_NONE;
            n_conts   = '0;
            n_accum   = '0;
        end

        if (!n_ok) begin
            n_cp = '0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
        if (in_take) begin
            r_in_byte <= i_byte_ch.in_byte;
            r_in_last <= i_byte_ch.text_last;
        end
    end

    // sequence state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= LEN_NONE;
            r_conts   <= '0;
            r_accum   <= '0;
            r_res_vld <= 1'b0;
            r_cnt     <= '0;
        end else if (load) begin
            r_seq_len <= n_seq_len;
            r_conts   <= n_conts;
            r_accum   <= n_accum;
            r_res_vld <= (n_cnt != '0);
            r_cnt     <= n_cnt;
        end else if (res_take) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_res_vld <= 1'b0;
            end
        end
        if (load) begin
            r_cp  <= n_cp;
            r_ok  <= n_ok;
            r_end <= r_in_last;
        end
    end

    // leading words of a burst are error markers, the final one carries the value
    assign o_cp_ch.valid      = r_res_vld;
    assign o_cp_ch.run_last   = (r_cnt == CNT_W'(1));
    assign o_cp_ch.code_point = o_cp_ch.run_last ? r_cp : '0;
    assign o_cp_ch.scalar_ok  = o_cp_ch.run_last && r_ok;
    assign o_cp_ch.text_end   = o_cp_ch.run_last && r_end;

    // a live result register always has words left, never more than four
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> (r_cnt != '0) && (r_cnt <= CNT_W'(4)))
        else $error("result count out of range");

    // a pending sequence always still needs a continuation
    a_seq_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_len != LEN_NONE) |->
            (r_seq_len >= LEN_2B) && (r_seq_len <= LEN_4B) &&
            ((LEN_W'(r_conts) + LEN_W'(1)) < r_seq_len))
        else $error("bad pending sequence state");

    // nothing may be pending once the end of a text leaves the block
    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_take && o_cp_ch.text_end) |-> (r_seq_len == LEN_NONE))
        else $error("sequence pending after text end");

    // a blocked byte stays put in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !load) |=> r_in_vld && $stable(r_in_byte) && $stable(r_in_last))
        else $error("input register lost a stalled byte");

    // only the final word of a burst can carry a scalar
    a_err_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && (r_cnt != CNT_W'(1))) |-> !o_cp_ch.scalar_ok && (o_cp_ch.code_point == '0))
        else $error("scalar before end of burst");

endmodule

// File: verif/utf8_stream_decoder_unit_test.sv
// self-checking testbench for the utf-8 stream decoder: byte driver, result monitor, predictor
module utf8_stream_decoder_unit_test;
    import utf8d_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              last;
        logic              drain_first;   // hold this word back until all results are in
    } t_text_byte;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            ok;
        logic            run_last;
        logic            text_end;
    } t_scalar_word;

    logic i_clk;
    logic i_rst_n;

    utf8d_in_if  byte_ch ();
    utf8d_out_if cp_ch ();

    utf8_stream_decoder_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (byte_ch),
        .o_cp_ch   (cp_ch)
    );

    t_text_byte   text_bytes[$];        // words still to be offered
    t_scalar_word pending_scalars[$];   // decoded results not yet seen
    t_scalar_word step_results[$];      // results of the byte being predicted

    // predictor state
    logic [LEN_W-1:0]  dec_len   = LEN_NONE;
    logic [CONT_W-1:0] dec_conts = '0;
    logic [CP_W-1:0]   dec_accum = '0;

    int sent_cnt     = 0;
    int err_cnt      = 0;
    int hold_left    = 0;
    bit holdoff_done = 1'b0;

    task automatic note_error(input string msg);
        err_cnt = err_cnt + 1;
        if (err_cnt <= 10) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic emit(input logic [CP_W-1:0] cp, input logic ok);
        t_scalar_word w;
        w.cp       = ok ? cp : '0;
        w.ok       = ok;
        w.run_last = 1'b0;
        w.text_end = 1'b0;
        step_results = {step_results, w};
    endtask

    task automatic clear_sequence();
        dec_len   = LEN_NONE;
        dec_conts = '0;
        dec_accum = '0;
    endtask

    // one error for the lead and one per continuation taken, at most four per byte
    task automatic flush_sequence();
        int count;
        count = 1 + int'(dec_conts);
        for (int i = 0; i < count && step_results.size() < 4; i = i + 1) emit('0, 1'b0);
        clear_sequence();
    endtask

    task automatic start_lead(input logic [BYTE_W-1:0] b);
        if (b[7] == 1'b0) begin
            emit(CP_W'(b), 1'b1);
        end else if (b[7:5] == 3'b110) begin
            dec_len   = LEN_2B;
            dec_accum = CP_W'(b[4:0]);
            dec_conts = '0;
        end else if (b[7:4] == 4'b1110) begin
            dec_len   = LEN_3B;
            dec_accum = CP_W'(b[3:0]);
            dec_conts = '0;
        end else if (b[7:3] == 5'b11110) begin
            dec_len   = LEN_4B;
            dec_accum = CP_W'(b[2:0]);
            dec_conts = '0;
        end else begin
            emit('0, 1'b0);
        end
    endtask

    task automatic decode_text_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [CP_W-1:0] lim;
        logic            good;
        t_scalar_word    w;
        step_results.delete();
        if (dec_len != LEN_NONE) begin
            if (b[7:6] == 2'b10) begin
                dec_accum = {dec_accum[CP_W-7:0], b[5:0]};
                dec_conts = dec_conts + CONT_W'(1);
                if (int'(dec_conts) + 1 >= int'(dec_len)) begin
                    lim  = (dec_len == LEN_2B) ? MIN_2B : (dec_len == LEN_3B) ? MIN_3B : MIN_4B;
                    good = (dec_accum >= lim) && (dec_accum <= CP_MAX) &&
                           !((dec_accum >= SURR_LO) && (dec_accum <= SURR_HI));
                    emit(dec_accum, good);
                    clear_sequence();
                end
            end else begin
                // broken sequence: flush it, then the byte starts over as a lead
                flush_sequence();
                start_lead(b);
            end
        end else begin
            start_lead(b);
        end
        // text ends inside a sequence
        if (last && dec_len != LEN_NONE) flush_sequence();
        if (step_results.size() > 0) begin
            w          = step_results[step_results.size()-1];
            w.run_last = 1'b1;
            w.text_end = last;
            step_results[step_results.size()-1] = w;
        end
        pending_scalars = {pending_scalars, step_results};
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        t_text_byte t;
        t.b           = b;
        t.last        = 1'b0;
        t.drain_first = 1'b0;
        text_bytes = {text_bytes, t};
    endtask

    // encode v in len bytes and queue the first keep of them
    task automatic push_encoded(input logic [CP_W-1:0] v, input int len, input int keep);
        logic [BYTE_W-1:0] enc [0:3];
        enc[1] = {2'b10, v[17:12]};
        enc[2] = {2'b10, v[11:6]};
        enc[3] = {2'b10, v[5:0]};
        case (len)
            1: enc[0] = {1'b0, v[6:0]};
            2: begin
                enc[0] = {3'b110, v[10:6]};
                enc[1] = {2'b10, v[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, v[15:12]};
                enc[1] = {2'b10, v[11:6]};
                enc[2] = {2'b10, v[5:0]};
            end
            default: enc[0] = {5'b11110, v[20:18]};
        endcase
        for (int i = 0; i < keep; i = i + 1) push_byte(enc[i]);
    endtask

    task automatic mark_text_end();
        t_text_byte t;
        t      = text_bytes[text_bytes.size()-1];
        t.last = 1'b1;
        text_bytes[text_bytes.size()-1] = t;
    endtask

    // idling plan: sender light / receiver heavy, then swapped, then none
    function automatic int idle_pct(input bit receiver);
        if (sent_cnt < 160) return receiver ? 70 : 15;
        if (sent_cnt < 320) return receiver ? 15 : 70;
        return 0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // byte driver: offers the head of text_bytes, predicts on every accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid     <= 1'b0;
            byte_ch.in_byte   <= '0;
            byte_ch.text_last <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                decode_text_byte(byte_ch.in_byte, byte_ch.text_last);
                text_bytes.delete(0);
                sent_cnt <= sent_cnt + 1;
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (text_bytes.size() > 0 && $urandom_range(99) >= idle_pct(1'b0) &&
                    (!text_bytes[0].drain_first || pending_scalars.size() == 0)) begin
                    byte_ch.valid     <= 1'b1;
                    byte_ch.in_byte   <= text_bytes[0].b;
                    byte_ch.text_last <= text_bytes[0].last;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off while the sender runs flat out
    always @(posedge i_clk) begin
        if (!holdoff_done && sent_cnt >= 340) begin
            hold_left    <= 400;
            holdoff_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor: compares each taken word with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cp_ch.ready <= 1'b0;
        end else begin
            if (cp_ch.valid && cp_ch.ready) begin
                if (pending_scalars.size() == 0) begin
                    note_error($sformatf("unexpected result cp=%h ok=%b run_last=%b text_end=%b",
                        cp_ch.code_point, cp_ch.scalar_ok, cp_ch.run_last, cp_ch.text_end));
                end else begin
                    if (cp_ch.code_point !== pending_scalars[0].cp ||
                        cp_ch.scalar_ok !== pending_scalars[0].ok ||
                        cp_ch.run_last !== pending_scalars[0].run_last ||
                        cp_ch.text_end !== pending_scalars[0].text_end) begin
                        note_error($sformatf(
                            "expected cp=%h ok=%b run_last=%b text_end=%b, got %h %b %b %b",
                            pending_scalars[0].cp, pending_scalars[0].ok,
                            pending_scalars[0].run_last, pending_scalars[0].text_end,
                            cp_ch.code_point, cp_ch.scalar_ok, cp_ch.run_last,
                            cp_ch.text_end));
                    end
                    pending_scalars.delete(0);
                end
            end
            cp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    initial begin
        int              r;
        int              len;
        int              n_chars;
        int              start;
        int              c;
        bit              end_now;
        bit              drain_marked;
        logic [CP_W-1:0] v;
        logic [BYTE_W-1:0] nb;

        i_rst_n      = 1'b0;
        drain_marked = 1'b0;

        // directed text: extremes, every lead kind and each error case
        push_byte(8'h00);
        push_byte(8'hC2); push_byte(8'h80);                          // smallest 2-byte
        push_byte(8'hC0); push_byte(8'h80);                          // overlong
        push_byte(8'hED); push_byte(8'hA0); push_byte(8'h80);        // surrogate
        push_byte(8'hF4); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);  // largest
        push_byte(8'hF4); push_byte(8'h90); push_byte(8'h80); push_byte(8'h80);  // too big
        push_byte(8'h80);                                            // stray continuation
        push_byte(8'hFF);                                            // invalid lead
        push_byte(8'hF0); push_byte(8'h90); push_byte(8'h80); push_byte(8'h7F);  // broken
        push_byte(8'hE2); push_byte(8'h82);                          // cut short at end
        mark_text_end();

        // random texts, mostly well formed
        while (text_bytes.size() < 474) begin
            start   = text_bytes.size();
            n_chars = $urandom_range(10, 1);
            end_now = 1'b0;
            for (c = 0; c < n_chars && !end_now; c = c + 1) begin
                r   = $urandom_range(99);
                len = $urandom_range(4, 2);
                if (r < 30) begin
                    push_encoded(CP_W'($urandom_range(8'h7F)), 1, 1);
                end else if (r < 48) begin
                    push_encoded(CP_W'($urandom_range(12'h7FF, 8'h80)), 2, 2);
                end else if (r < 63) begin
                    v = CP_W'($urandom_range(16'hFFFF, 12'h800));
                    if (v >= SURR_LO && v <= SURR_HI) v = v ^ 21'h2000;
                    push_encoded(v, 3, 3);
                end else if (r < 75) begin
                    push_encoded(CP_W'($urandom_range(21'h10FFFF, 21'h10000)), 4, 4);
                end else if (r < 79) begin
                    // overlong form of a smaller value
                    if (len == 2) v = CP_W'($urandom_range(8'h7F));
                    else if (len == 3) v = CP_W'($urandom_range(12'h7FF));
                    else v = CP_W'($urandom_range(16'hFFFF));
                    push_encoded(v, len, len);
                end else if (r < 82) begin
                    push_encoded(CP_W'($urandom_range(SURR_HI, SURR_LO)), 3, 3);
                end else if (r < 85) begin
                    push_encoded(CP_W'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4);
                end else if (r < 90) begin
                    // sequence broken by a byte that is not a continuation
                    push_encoded(CP_W'($urandom_range(21'h1FFFFF)), len,
                                 $urandom_range(len - 1, 1));
                    nb = BYTE_W'($urandom_range(255));
                    if (nb[7:6] == 2'b10) nb[6] = 1'b1;
                    push_byte(nb);
                end else if (r < 95) begin
                    push_byte(BYTE_W'($urandom_range(255)));
                end else begin
                    // text stops inside a sequence
                    push_encoded(CP_W'($urandom_range(21'h1FFFFF)), len,
                                 $urandom_range(len - 1, 1));
                    end_now = 1'b1;
                end
            end
            mark_text_end();
            if (!drain_marked && start >= 300) begin
                text_bytes[start].drain_first = 1'b1;
                drain_marked = 1'b1;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_bytes.size() != 0 || pending_scalars.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_scalars.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_scalars.size()));

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
